[hdl/ule_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the serial line editor.
// Holds the control enum, the command/status structs and the fixed reply texts.
// No dependencies.
package ule_pkg;

    // Special input characters
    localparam logic [7:0] CHR_BS  = 8'h08;
    localparam logic [7:0] CHR_DEL = 8'h7F;
    localparam logic [7:0] CHR_CR  = 8'h0D;
    localparam logic [7:0] CHR_LF  = 8'h0A;

    // Fixed reply texts, first character in the top byte
    localparam int ERASE_LEN = 3;
    localparam int ECHO_LEN  = 9;
    localparam int FULL_LEN  = 39;
    localparam logic [ERASE_LEN*8-1:0] ERASE_TEXT = "\010 \010";
    localparam logic [ECHO_LEN*8-1:0]  ECHO_TEXT  = "\015\012Echo > ";
    localparam logic [FULL_LEN*8-1:0]  FULL_TEXT  =
        "\015\012Buffer lleno! Enter para limpiar.\015\012> ";

    typedef enum logic [1:0] {
        MSG_ERASE,
        MSG_ECHO,
        MSG_FULL
    } msg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHAR,
        ST_MSG,
        ST_RD,
        ST_EM
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic push_char;
        logic pop_char;
        logic start_submit;
        logic start_full;
        logic emit_msg;
        logic begin_echo;
        logic read_next;
        logic emit_cur;
        logic cur_last;
        logic advance_echo;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_erase;
        logic is_submit;
        logic line_empty;
        logic line_full;
        logic out_free;
        logic msg_end;
        logic echo_more;
        logic echo_last;
    } sts_t;

    function automatic logic [5:0] msg_len(msg_t sel);
        logic [5:0] len;
        len = 6'(ERASE_LEN);
        unique case (sel)
            MSG_ERASE: len = 6'(ERASE_LEN);
            MSG_ECHO:  len = 6'(ECHO_LEN);
            MSG_FULL:  len = 6'(FULL_LEN);
            default:   len = 6'(ERASE_LEN);
        endcase
        return len;
    endfunction

    function automatic logic [7:0] msg_byte(msg_t sel, logic [5:0] pos);
        logic [5:0] r;
        logic [7:0] b;
        b = 8'h00;
        r = '0;
        unique case (sel)
            MSG_ERASE: begin
                r = 6'(ERASE_LEN - 1) - pos;
                b = ERASE_TEXT[r*8 +: 8];
            end
            MSG_ECHO: begin
                r = 6'(ECHO_LEN - 1) - pos;
                b = ECHO_TEXT[r*8 +: 8];
            end
            MSG_FULL: begin
                r = 6'(FULL_LEN - 1) - pos;
                b = FULL_TEXT[r*8 +: 8];
            end
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

[hdl/ule_ctrl.sv]
`timescale 1ns / 1ps
// Controller of the serial line editor: sequences each request through the datapath.
// Depends on ule_pkg.
module ule_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  ule_pkg::sts_t sts,
    output ule_pkg::cmd_t cmd
);

    ule_pkg::state_t state_reg;
    ule_pkg::state_t state_next;

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ule_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Advance state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ule_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (sts.is_erase || sts.is_submit) begin
                        if (!sts.line_empty) begin
                            state_next = ule_pkg::ST_MSG;
                        end
                    end else if (!sts.line_full) begin
                        state_next = ule_pkg::ST_CHAR;
                    end else begin
                        state_next = ule_pkg::ST_MSG;
                    end
                end
            end
            ule_pkg::ST_CHAR: begin
                if (sts.out_free) begin
                    state_next = ule_pkg::ST_IDLE;
                end
            end
            ule_pkg::ST_MSG: begin
                if (sts.out_free && sts.msg_end) begin
                    state_next = sts.echo_more ? ule_pkg::ST_RD : ule_pkg::ST_IDLE;
                end
            end
            ule_pkg::ST_RD: begin
                state_next = ule_pkg::ST_EM;
            end
            ule_pkg::ST_EM: begin
                if (sts.out_free) begin
                    state_next = sts.echo_last ? ule_pkg::ST_IDLE : ule_pkg::ST_RD;
                end
            end
            default: state_next = ule_pkg::ST_IDLE;
        endcase
    end

    // Drive commands
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ule_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (sts.is_erase) begin
                        cmd.pop_char = !sts.line_empty;
                    end else if (sts.is_submit) begin
                        cmd.start_submit = !sts.line_empty;
                    end else if (!sts.line_full) begin
                        cmd.push_char = 1'b1;
                    end else begin
                        cmd.start_full = 1'b1;
                    end
                end
            end
            ule_pkg::ST_CHAR: begin
                cmd.emit_cur = sts.out_free;
                cmd.cur_last = 1'b1;
            end
            ule_pkg::ST_MSG: begin
                cmd.emit_msg   = sts.out_free;
                cmd.begin_echo = sts.out_free && sts.msg_end && sts.echo_more;
            end
            ule_pkg::ST_RD: begin
                cmd.read_next = 1'b1;
            end
            ule_pkg::ST_EM: begin
                cmd.emit_cur     = sts.out_free;
                cmd.cur_last     = sts.echo_last;
                cmd.advance_echo = sts.out_free && !sts.echo_last;
            end
            default: cmd = '0;
        endcase
    end

endmodule

[hdl/ule_dpath.sv]
`timescale 1ns / 1ps
// Datapath of the serial line editor: line store, fill count, reply pointer, output register.
// Depends on ule_pkg.
module ule_dpath #(
    parameter int LINE_CAP = 32
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [7:0]    s_rx_byte,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [7:0]    m_tx_byte,
    output logic          m_last_of_run,
    input  ule_pkg::cmd_t cmd,
    output ule_pkg::sts_t sts
);

    localparam int DEPTH  = LINE_CAP - 1;
    localparam int CNT_W  = $clog2(LINE_CAP);
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [7:0]        mem [DEPTH];
    logic [7:0]        rd_data_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CNT_W-1:0]  len_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  idx_inc;
    logic [7:0]        cur_reg;
    ule_pkg::msg_t     sel_reg;
    logic [5:0]        pos_reg;
    logic [7:0]        tx_reg;
    logic              last_reg;
    logic              m_valid_reg;
    logic              m_valid_next;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              msg_last;

    assign idx_inc = idx_reg + 1'b1;
    assign rd_en   = cmd.start_submit || (cmd.read_next && (idx_inc < len_reg));
    assign rd_addr = cmd.start_submit ? '0 : idx_inc[ADDR_W-1:0];

    // Line store: one write, one registered read
    always_ff @(posedge aclk) begin
        if (cmd.push_char) begin
            mem[count_reg[ADDR_W-1:0]] <= s_rx_byte;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Fill count
    always_comb begin
        count_next = count_reg;
        if (cmd.push_char) begin
            count_next = count_reg + 1'b1;
        end else if (cmd.pop_char) begin
            count_next = count_reg - 1'b1;
        end else if (cmd.start_submit || cmd.start_full) begin
            count_next = '0;
        end
    end

    // Status towards the controller
    always_comb begin
        sts.is_erase   = (s_rx_byte == ule_pkg::CHR_BS) || (s_rx_byte == ule_pkg::CHR_DEL);
        sts.is_submit  = (s_rx_byte == ule_pkg::CHR_CR) || (s_rx_byte == ule_pkg::CHR_LF);
        sts.line_empty = (count_reg == '0);
        sts.line_full  = (count_reg == CNT_W'(DEPTH));
        sts.out_free   = !m_valid_reg || m_ready;
        sts.msg_end    = (pos_reg == (ule_pkg::msg_len(sel_reg) - 6'd1));
        sts.echo_more  = (sel_reg == ule_pkg::MSG_ECHO) && (rd_data_reg != 8'h00);
        sts.echo_last  = (idx_inc == len_reg) || (rd_data_reg == 8'h00);
    end

    assign msg_last = sts.msg_end && !sts.echo_more;

    // Output register handshake
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.emit_msg || cmd.emit_cur) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Reply sequencing and payload registers
    always_ff @(posedge aclk) begin
        if (cmd.start_submit) begin
            len_reg <= count_reg;
        end
        if (cmd.pop_char) begin
            sel_reg <= ule_pkg::MSG_ERASE;
            pos_reg <= '0;
        end else if (cmd.start_submit) begin
            sel_reg <= ule_pkg::MSG_ECHO;
            pos_reg <= '0;
        end else if (cmd.start_full) begin
            sel_reg <= ule_pkg::MSG_FULL;
            pos_reg <= '0;
        end else if (cmd.emit_msg) begin
            pos_reg <= pos_reg + 6'd1;
        end
        if (cmd.push_char) begin
            cur_reg <= s_rx_byte;
        end else if (cmd.begin_echo || cmd.advance_echo) begin
            cur_reg <= rd_data_reg;
        end
        if (cmd.begin_echo) begin
            idx_reg <= '0;
        end else if (cmd.advance_echo) begin
            idx_reg <= idx_inc;
        end
        if (cmd.emit_msg) begin
            tx_reg   <= ule_pkg::msg_byte(sel_reg, pos_reg);
            last_reg <= msg_last;
        end else if (cmd.emit_cur) begin
            tx_reg   <= cur_reg;
            last_reg <= cmd.cur_last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_tx_byte     = tx_reg;
    assign m_last_of_run = last_reg;

endmodule

[hdl/uart_line_editor_echo.sv]
`timescale 1ns / 1ps
// Top level of the serial line editor with echo.
// Instantiates ule_ctrl and ule_dpath; depends on ule_pkg.
//
//  channel | ports                              | direction | payload
//  --------+------------------------------------+-----------+--------------------------
//  input   | s_valid, s_ready, s_rx_byte        | in        | received byte
//  result  | m_valid, m_ready, m_tx_byte,       | out       | reply byte, end-of-reply
//          | m_last_of_run                      |           | flag
//
// A request is taken only while the controller is idle. Its reply bytes leave
// through one output register while m_ready stays high: one per cycle for the fixed
// texts, while each echoed character is first read from the line store, then emitted.
// Reply bytes per request: stored character 1; erase 3; line full 39. Submit: 9
// prompt bytes, then the echoed characters, at most LINE_CAP-1 of them.
// Erase or submit on an empty line gives no reply.
// Reset clears the fill count, the controller and the output valid; the line
// store is not cleared. A stall on m_ready holds the current byte and the sequence.
module uart_line_editor_echo #(
    parameter int LINE_CAP = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_tx_byte,
    output logic       m_last_of_run
);

    ule_pkg::cmd_t cmd;
    ule_pkg::sts_t sts;

    ule_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ule_dpath #(
        .LINE_CAP (LINE_CAP)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_rx_byte     (s_rx_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_tx_byte     (m_tx_byte),
        .m_last_of_run (m_last_of_run),
        .cmd           (cmd),
        .sts           (sts)
    );

endmodule

[hdl/ule_chk.sv]
`timescale 1ns / 1ps
// Port-level checks of the serial line editor, bound to the top level.
// Depends only on the ports of uart_line_editor_echo.
module ule_chk (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [7:0] s_rx_byte,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_tx_byte,
    input logic       m_last_of_run
);

    // A stalled reply byte holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_tx_byte) && $stable(m_last_of_run))
        else $error("reply byte changed under stall");

    // No reply byte straight out of reset
    a_rst_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("reply valid after reset");

    // No new request while a reply run is unfinished
    a_run_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last_of_run |-> !s_ready)
        else $error("request taken in the middle of a reply");

    // A plain character always gives a reply, so the block leaves idle
    a_char_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_rx_byte[7:5] != 3'b000) && (s_rx_byte != 8'h7F)
        |=> !s_ready)
        else $error("plain character did not start a reply");

endmodule

bind uart_line_editor_echo ule_chk u_ule_chk (.*);

[verif/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for uart_line_editor_echo: a directed table, then random edit sessions.
// Replies are predicted from a local copy of the line store and fill count; needs only the RTL.
module tb;

    localparam int LINE_CAP     = 32;
    localparam int STORE_DEPTH  = LINE_CAP - 1;
    localparam int RAND_ITEMS   = 460;
    localparam int DRAIN_CYCLES = 120;

    // Keys with a meaning of their own
    localparam logic [7:0] KEY_BS  = 8'h08;
    localparam logic [7:0] KEY_DEL = 8'h7F;
    localparam logic [7:0] KEY_CR  = 8'h0D;
    localparam logic [7:0] KEY_LF  = 8'h0A;

    // How the replies to a request are obtained
    typedef enum logic [1:0] {
        EXP_MODEL,
        EXP_NONE,
        EXP_SELF
    } exp_kind_t;

    typedef struct packed {
        exp_kind_t  kind;
        logic [7:0] rx;
    } dir_row_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last;
    } tx_item_t;

    logic       aclk    = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_rx_byte = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_tx_byte;
    logic       m_last_of_run;

    exp_kind_t  item_kind = EXP_MODEL;
    int         fail_cnt = 0;
    int         replied_items = 0;
    int         burst_left = 0;

    // Local copy of the editor state
    logic [7:0] line_buf [0:STORE_DEPTH-1];
    int         fill_cnt = 0;
    logic [7:0] tx_run [$];
    tx_item_t   tx_pending [$];
    tx_item_t   tx_head;

    string erase_txt = "\010 \010";
    string echo_txt  = "\015\012Echo > ";
    string full_txt  = "\015\012Buffer lleno! Enter para limpiar.\015\012> ";

    dir_row_t dir_rows [25];

    logic [5:0] rdy_phase = '0;
    logic [1:0] rdy_mode  = '0;
    logic [7:0] rdy_pat   = 8'hFF;

    uart_line_editor_echo #(
        .LINE_CAP(LINE_CAP)
    ) DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_rx_byte    (s_rx_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_tx_byte    (m_tx_byte),
        .m_last_of_run(m_last_of_run)
    );

    always #5 aclk = ~aclk;

    function automatic void append_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            tx_run.push_back(s[i]);
        end
    endfunction

    // Work out the reply bytes of one received byte and advance the line state
    function automatic void edit_line(logic [7:0] b);
        tx_run.delete();
        if (b == KEY_BS || b == KEY_DEL) begin
            if (fill_cnt > 0) begin
                fill_cnt--;
                append_text(erase_txt);
            end
        end else if (b == KEY_CR || b == KEY_LF) begin
            if (fill_cnt > 0) begin
                append_text(echo_txt);
                for (int i = 0; i < fill_cnt; i++) begin
                    if (line_buf[i] == 8'h00) break;
                    tx_run.push_back(line_buf[i]);
                end
                fill_cnt = 0;
            end
        end else if (fill_cnt < STORE_DEPTH) begin
            line_buf[fill_cnt] = b;
            fill_cnt++;
            tx_run.push_back(b);
        end else begin
            append_text(full_txt);
            fill_cnt = 0;
        end
    endfunction

    // Printable or binary character, now and then a zero byte
    function automatic logic [7:0] line_char();
        logic [7:0] c;
        if ($urandom_range(0, 39) == 0) return 8'h00;
        do begin
            c = 8'($urandom_range(0, 255));
        end while (c == KEY_BS || c == KEY_DEL || c == KEY_CR || c == KEY_LF);
        return c;
    endfunction

    function automatic logic [7:0] erase_key();
        return ($urandom_range(0, 1) != 0) ? KEY_BS : KEY_DEL;
    endfunction

    function automatic logic [7:0] submit_key();
        return ($urandom_range(0, 1) != 0) ? KEY_CR : KEY_LF;
    endfunction

    // Present one request, in bursts separated by random gaps, and hold until taken
    task automatic send_byte(input logic [7:0] b, input exp_kind_t kind);
        int gap;
        @(negedge aclk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        item_kind <= kind;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Receiver: always ready, a rotating pattern, or random stalls, switched whenever rdy_phase wraps
    always @(negedge aclk) begin
        rdy_phase <= rdy_phase + 6'd1;
        if (rdy_phase == '0) begin
            rdy_mode <= 2'($urandom_range(0, 2));
            rdy_pat  <= 8'($urandom) | 8'h01;
        end
        case (rdy_mode)
            2'd0:    m_ready <= 1'b1;
            2'd1:    m_ready <= rdy_pat[rdy_phase[2:0]];
            default: m_ready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // Record expectations on each taken request, then check each taken reply byte
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                edit_line(s_rx_byte);
                if (tx_run.size() != 0) replied_items++;
                case (item_kind)
                    EXP_NONE: begin
                    end
                    EXP_SELF: tx_pending.push_back({s_rx_byte, 1'b1});
                    default: begin
                        for (int i = 0; i < tx_run.size(); i++) begin
                            tx_pending.push_back({tx_run[i], i == tx_run.size() - 1});
                        end
                    end
                endcase
            end
            if (m_valid && m_ready) begin
                if (tx_pending.size() == 0) begin
                    $error("unexpected reply: tx_byte %h last_of_run %b", m_tx_byte,
                           m_last_of_run);
                    fail_cnt++;
                end else begin
                    tx_head = tx_pending.pop_front();
                    if (m_tx_byte !== tx_head.tx_byte) begin
                        $error("tx_byte: expected %h, actual %h", tx_head.tx_byte, m_tx_byte);
                        fail_cnt++;
                    end
                    if (m_last_of_run !== tx_head.last) begin
                        $error("last_of_run: expected %b, actual %b", tx_head.last,
                               m_last_of_run);
                        fail_cnt++;
                    end
                end
            end
        end
    end

    initial begin : stimulus
        int n;
        int mode;
        dir_rows = '{
            // erase and submit on an empty line: no reply
            '{EXP_NONE,  KEY_BS},
            '{EXP_NONE,  KEY_DEL},
            '{EXP_NONE,  KEY_CR},
            '{EXP_NONE,  KEY_LF},
            // extremes of the byte are stored and echoed
            '{EXP_SELF,  8'h00},
            '{EXP_SELF,  8'hFF},
            '{EXP_SELF,  8'h41},
            '{EXP_MODEL, KEY_DEL},
            // zero byte first: prompt only, line still emptied
            '{EXP_MODEL, KEY_CR},
            '{EXP_NONE,  KEY_LF},
            '{EXP_SELF,  8'h68},
            '{EXP_SELF,  8'h69},
            '{EXP_MODEL, KEY_BS},
            '{EXP_SELF,  8'h6F},
            '{EXP_SELF,  8'h80},
            '{EXP_SELF,  8'h01},
            '{EXP_MODEL, KEY_LF},
            // zero byte in mid-line stops the echo there
            '{EXP_SELF,  8'h7E},
            '{EXP_SELF,  8'h00},
            '{EXP_SELF,  8'h55},
            '{EXP_MODEL, KEY_CR},
            // neighbours of the control keys are ordinary characters
            '{EXP_SELF,  8'h0C},
            '{EXP_SELF,  8'h0E},
            '{EXP_MODEL, KEY_DEL},
            '{EXP_MODEL, KEY_BS}
        };

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            send_byte(dir_rows[i].rx, dir_rows[i].kind);
        end

        // Random edit sessions, mostly well-formed lines
        while (replied_items < RAND_ITEMS) begin
            mode = $urandom_range(0, 19);
            if (mode < 12) begin
                // ordinary line with the odd correction
                n = $urandom_range(1, STORE_DEPTH);
                for (int k = 0; k < n; k++) begin
                    send_byte(line_char(), EXP_MODEL);
                    if ($urandom_range(0, 7) == 0) send_byte(erase_key(), EXP_MODEL);
                end
                send_byte(submit_key(), EXP_MODEL);
            end else if (mode < 14) begin
                // a full line's worth of characters, then a submit
                repeat (STORE_DEPTH) send_byte(line_char(), EXP_MODEL);
                send_byte(submit_key(), EXP_MODEL);
            end else if (mode < 17) begin
                // overrun the line, then carry on typing
                n = STORE_DEPTH + $urandom_range(1, 3);
                repeat (n) send_byte(line_char(), EXP_MODEL);
                if ($urandom_range(0, 1) != 0) send_byte(submit_key(), EXP_MODEL);
            end else begin
                // noise: any byte at all
                n = $urandom_range(1, 6);
                repeat (n) send_byte(8'($urandom_range(0, 255)), EXP_MODEL);
            end
        end

        @(negedge aclk);
        s_valid <= 1'b0;

        // Drain outstanding replies, then watch for strays
        while (tx_pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_cnt == 0) begin
            $display("PASS uart_line_editor_echo");
        end else begin
            $display("FAIL uart_line_editor_echo");
        end
        $finish;
    end

    // Hold a hard limit on run time
    initial begin
        #(10_000_000);
        $display("FAIL uart_line_editor_echo");
        $finish;
    end

endmodule
